>>> rtl/fps_pkg.sv
// package for the fenwick point-set / range-sum store
// types, codes and widths used by the top level; no dependencies

package fps_pkg;

	localparam int CAPACITY_DEF   = 1024;
	localparam int VALUE_BITS_DEF = 32;

	localparam int MODE_W     = 3;
	localparam int STATUS_W   = 2;
	localparam int SUM_W      = 42;
	localparam int ELEM_OUT_W = 32;

	typedef enum logic [MODE_W-1:0] {
		MODE_SET    = 3'd0,
		MODE_SUM    = 3'd1,
		MODE_APPEND = 3'd2,
		MODE_REMOVE = 3'd3,
		MODE_READ   = 3'd4
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK    = 2'd0,
		STATUS_RANGE = 2'd1,
		STATUS_FULL  = 2'd2,
		STATUS_EMPTY = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SET_RD,
		ST_SET_DELTA,
		ST_UPD_RD,
		ST_UPD_WR,
		ST_SUM_A,
		ST_SUM_B,
		ST_APP_WR,
		ST_READ_RD,
		ST_READ_DATA,
		ST_FINISH
	} state_t;

endpackage

>>> rtl/fenwick_point_set_range_sum.sv
// top level of the fenwick point-set / range-sum store: sequencer, walk datapath
// depends on fps_pkg and two fps_ram instances (tree nodes, element values)
//
// channel  | handshake             | payload
// request  | in_valid / in_ready   | mode, first_index, last_index, value
// result   | out_valid / out_ready | range_sum, element_value, element_count, status
//
// set reads and rewrites each tree node on its update walk in turn; sum and append
// read one tree node per step on each of the two prefix walks, through the single read
// port of the tree memory; read, remove and rejected requests touch no tree node.
// reset clears the count, the sequencer and the result valid and read pending flags only; the memories are not cleared.
// a result held by out_ready low stalls the sequencer in its last state only.

module fenwick_point_set_range_sum import fps_pkg::*; #(
	parameter int CAPACITY   = CAPACITY_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF,
	localparam int IDX_W = $clog2(CAPACITY),
	localparam int CNT_W = $clog2(CAPACITY + 1)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [MODE_W-1:0]            mode,
	input  logic [IDX_W-1:0]             first_index,
	input  logic [IDX_W-1:0]             last_index,
	input  logic signed [ELEM_OUT_W-1:0] value,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [SUM_W-1:0]      range_sum,
	output logic signed [ELEM_OUT_W-1:0] element_value,
	output logic [CNT_W-1:0]             element_count,
	output logic [STATUS_W-1:0]          status
);

	localparam int ELEM_W = (VALUE_BITS < ELEM_OUT_W) ? VALUE_BITS : ELEM_OUT_W;
	localparam int PTR_W  = IDX_W + 1;

	state_t state_q, state_d;
	logic [CNT_W-1:0] count_q;
	logic out_valid_q;
	logic pend_s1, neg_s1;

	logic [IDX_W-1:0] first_q;
	logic signed [ELEM_W-1:0] val_q;
	logic is_app_q, is_sum_q;
	status_t res_status_q;
	logic signed [ELEM_W-1:0] res_elem_q;
	logic [SUM_W-1:0] delta_q, acc_q;
	logic [PTR_W-1:0] idx_q, b_q;

	logic tree_we, tree_re;
	logic [IDX_W-1:0] tree_waddr, tree_raddr;
	logic [SUM_W-1:0] tree_wdata, tree_rdata;
	logic elem_we, elem_re;
	logic [IDX_W-1:0] elem_waddr, elem_raddr;
	logic [ELEM_W-1:0] elem_rdata;

	logic in_acc, out_load;
	mode_t in_mode;
	logic first_ok, last_ok, order_ok, full, empty;
	logic signed [ELEM_W-1:0] val_in;
	logic idx_neg;
	logic [PTR_W-1:0] idx_down, idx_up;
	logic up_in_use;
	logic [IDX_W-1:0] app_n, app_low;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign in_mode   = mode_t'(mode);
	assign first_ok  = CNT_W'(first_index) < count_q;
	assign last_ok   = CNT_W'(last_index) < count_q;
	assign order_ok  = first_index <= last_index;
	assign full      = count_q == CNT_W'(CAPACITY);
	assign empty     = count_q == '0;
	assign val_in    = value[ELEM_W-1:0];

	// prefix walk moves down, update walk moves up
	assign idx_neg   = idx_q[PTR_W-1];
	assign idx_down  = (idx_q & (idx_q + PTR_W'(1))) - PTR_W'(1);
	assign idx_up    = idx_q | (idx_q + PTR_W'(1));
	assign up_in_use = idx_up < PTR_W'(count_q);
	assign app_n     = count_q[IDX_W-1:0];
	assign app_low   = app_n & (app_n + IDX_W'(1));

	always_comb begin
		state_d    = state_q;
		out_load   = 1'b0;
		tree_re    = 1'b0;
		tree_we    = 1'b0;
		tree_raddr = idx_q[IDX_W-1:0];
		tree_waddr = idx_q[IDX_W-1:0];
		tree_wdata = tree_rdata + delta_q;
		elem_re    = 1'b0;
		elem_we    = 1'b0;
		elem_raddr = first_q;
		elem_waddr = first_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					case (in_mode)
						MODE_SET:    state_d = first_ok ? ST_SET_RD : ST_FINISH;
						MODE_SUM:    state_d = (order_ok && last_ok) ? ST_SUM_A : ST_FINISH;
						MODE_APPEND: state_d = full ? ST_FINISH : ST_SUM_A;
						MODE_READ:   state_d = first_ok ? ST_READ_RD : ST_FINISH;
						default:     state_d = ST_FINISH;
					endcase
				end
			end
			ST_SET_RD: begin
				elem_re = 1'b1;
				state_d = ST_SET_DELTA;
			end
			ST_SET_DELTA: begin
				elem_we = 1'b1;
				state_d = ST_UPD_RD;
			end
			ST_UPD_RD: begin
				tree_re = 1'b1;
				state_d = ST_UPD_WR;
			end
			ST_UPD_WR: begin
				tree_we = 1'b1;
				state_d = up_in_use ? ST_UPD_RD : ST_FINISH;
			end
			ST_SUM_A: begin
				tree_re = !idx_neg;
				if (idx_neg) begin
					state_d = ST_SUM_B;
				end
			end
			ST_SUM_B: begin
				tree_re = !idx_neg;
				if (idx_neg) begin
					state_d = is_app_q ? ST_APP_WR : ST_FINISH;
				end
			end
			ST_APP_WR: begin
				tree_we    = 1'b1;
				tree_waddr = app_n;
				tree_wdata = acc_q;
				elem_we    = 1'b1;
				elem_waddr = app_n;
				state_d    = ST_FINISH;
			end
			ST_READ_RD: begin
				elem_re = 1'b1;
				state_d = ST_READ_DATA;
			end
			ST_READ_DATA: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
			pend_s1     <= 1'b0;
		end else begin
			if (in_acc && in_mode == MODE_REMOVE && !empty) begin
				count_q <= count_q - CNT_W'(1);
			end else if (state_q == ST_APP_WR) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			pend_s1 <= tree_re && (state_q == ST_SUM_A || state_q == ST_SUM_B);
		end
	end

	always_ff @(posedge clk) begin
		neg_s1 <= (state_q == ST_SUM_B);
		if (in_acc) begin
			first_q      <= first_index;
			val_q        <= val_in;
			is_app_q     <= (in_mode == MODE_APPEND);
			is_sum_q     <= (in_mode == MODE_SUM) && order_ok && last_ok;
			res_elem_q   <= '0;
			acc_q        <= '0;
			idx_q        <= PTR_W'(last_index);
			b_q          <= PTR_W'(first_index) - PTR_W'(1);
			res_status_q <= STATUS_OK;
			case (in_mode)
				MODE_SET, MODE_READ: begin
					if (!first_ok) begin
						res_status_q <= STATUS_RANGE;
					end
				end
				MODE_SUM: begin
					if (!(order_ok && last_ok)) begin
						res_status_q <= STATUS_RANGE;
					end
				end
				MODE_APPEND: begin
					acc_q <= SUM_W'(val_in);
					idx_q <= PTR_W'(app_n) - PTR_W'(1);
					b_q   <= PTR_W'(app_low) - PTR_W'(1);
					if (full) begin
						res_status_q <= STATUS_FULL;
					end
				end
				MODE_REMOVE: begin
					if (empty) begin
						res_status_q <= STATUS_EMPTY;
					end
				end
				default: begin
					res_status_q <= STATUS_OK;
				end
			endcase
		end else begin
			case (state_q)
				ST_SET_DELTA: begin
					delta_q <= SUM_W'(val_q) - SUM_W'($signed(elem_rdata));
					idx_q   <= PTR_W'(first_q);
				end
				ST_UPD_WR: begin
					idx_q <= idx_up;
				end
				ST_SUM_A, ST_SUM_B: begin
					if (pend_s1) begin
						acc_q <= neg_s1 ? acc_q - tree_rdata : acc_q + tree_rdata;
					end
					if (idx_neg && state_q == ST_SUM_A) begin
						idx_q <= b_q;
					end else if (!idx_neg) begin
						idx_q <= idx_down;
					end
				end
				ST_READ_DATA: begin
					res_elem_q <= $signed(elem_rdata);
				end
				default: begin
					idx_q <= idx_q;
				end
			endcase
		end
		if (out_load) begin
			range_sum     <= is_sum_q ? $signed(acc_q) : '0;
			element_value <= ELEM_OUT_W'(res_elem_q);
			element_count <= count_q;
			status        <= res_status_q;
		end
	end

	fps_ram #(
		.WIDTH(SUM_W),
		.DEPTH(CAPACITY)
	) u_tree_ram (
		.clk  (clk),
		.we   (tree_we),
		.waddr(tree_waddr),
		.wdata(tree_wdata),
		.re   (tree_re),
		.raddr(tree_raddr),
		.rdata(tree_rdata)
	);

	fps_ram #(
		.WIDTH(ELEM_W),
		.DEPTH(CAPACITY)
	) u_elem_ram (
		.clk  (clk),
		.we   (elem_we),
		.waddr(elem_waddr),
		.wdata(val_q),
		.re   (elem_re),
		.raddr(elem_raddr),
		.rdata(elem_rdata)
	);

	a_tree_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(tree_re && tree_we && tree_raddr == tree_waddr))
		else $error("tree read and write hit the same node");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("element count above capacity");

	a_pend_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> (state_q == ST_SUM_A || state_q == ST_SUM_B))
		else $error("tree read data pending outside a prefix walk");

	a_append_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_APP_WR) |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("append did not grow the count");

endmodule

>>> rtl/fps_ram.sv
// generic simple dual-port ram, one write and one registered read port
// depends on nothing

module fps_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
